// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/ksl_pkg.sv -----
// Shared constants, codes, command/status types and key decode for the logger.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksl_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int SAMPLE_BITS = 10;

  localparam int KEY_W     = 5;
  localparam int VAL_W     = 10;
  localparam int OUT_IDX_W = 5;
  localparam int KIND_W    = 3;
  localparam int ENTRY_W   = 14;
  localparam int PROD_W    = ENTRY_W + 4;
  localparam int ENTRY_MAX = 9999;

  localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W  = VAL_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam logic [VAL_W-1:0] SMP_MASK =
    (SAMPLE_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((1 << SAMPLE_BITS) - 1);

  localparam logic [KEY_W-1:0] KEY_ERR_A   = 5'd4;
  localparam logic [KEY_W-1:0] KEY_ERR_B   = 5'd12;
  localparam logic [KEY_W-1:0] KEY_MEASURE = 5'd13;
  localparam logic [KEY_W-1:0] KEY_SHOW    = 5'd14;
  localparam logic [KEY_W-1:0] KEY_ALL     = 5'd15;
  localparam logic [KEY_W-1:0] KEY_AVG     = 5'd16;

  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRAP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SHOWN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_AVG    = 3'd5;

  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_DIGIT = 3'd1;
  localparam logic [2:0] CLS_ERR   = 3'd2;
  localparam logic [2:0] CLS_MEAS  = 3'd3;
  localparam logic [2:0] CLS_SHOW  = 3'd4;
  localparam logic [2:0] CLS_ALL   = 3'd5;
  localparam logic [2:0] CLS_AVG   = 3'd6;

  typedef struct packed {
    logic capture;
    logic digit_upd;
    logic clr_entry;
    logic meas_wr;
    logic emit_err;
    logic emit_meas;
    logic rd_show;
    logic emit_show;
    logic rd_pos;
    logic pos_clr;
    logic pos_inc;
    logic emit_list;
    logic acc_clr;
    logic acc_add;
    logic div_start;
    logic div_step;
    logic emit_avg;
  } ksl_cmd_t;

  typedef struct packed {
    logic [2:0] cls;
    logic       show_ok;
    logic       empty;
    logic       list_last;
    logic       div_done;
    logic       can_load;
  } ksl_sts_t;

  function automatic logic [2:0] key_class(input logic [KEY_W-1:0] key);
    logic [2:0] c;
    c = CLS_NONE;
    if (key inside {5'd1, 5'd2, 5'd3, [5'd5:5'd11]}) c = CLS_DIGIT;
    else if (key == KEY_ERR_A || key == KEY_ERR_B) c = CLS_ERR;
    else if (key == KEY_MEASURE) c = CLS_MEAS;
    else if (key == KEY_SHOW) c = CLS_SHOW;
    else if (key == KEY_ALL) c = CLS_ALL;
    else if (key == KEY_AVG) c = CLS_AVG;
    return c;
  endfunction

  function automatic logic [3:0] key_digit(input logic [KEY_W-1:0] key);
    logic [3:0] d;
    case (key)
      5'd1:    d = 4'd1;
      5'd2:    d = 4'd4;
      5'd3:    d = 4'd7;
      5'd5:    d = 4'd2;
      5'd6:    d = 4'd5;
      5'd7:    d = 4'd8;
      5'd8:    d = 4'd0;
      5'd9:    d = 4'd3;
      5'd10:   d = 4'd6;
      5'd11:   d = 4'd9;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] x);
    logic [IDX_W+OUT_IDX_W-1:0] t;
    t = {{OUT_IDX_W{1'b0}}, x};
    return t[OUT_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ksl_dpath.sv -----
// Logger datapath: entry number, sample store, list/sum walk, divider, output beat.
// Depends on ksl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksl_dpath
  import ksl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [KEY_W-1:0]     in_key_code,
  input  wire logic [VAL_W-1:0]     in_sample,
  input  wire ksl_cmd_t             cmd,
  output ksl_sts_t                  sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [KIND_W-1:0]         out_kind,
  output logic [VAL_W-1:0]          out_value,
  output logic [OUT_IDX_W-1:0]      out_index,
  output logic                      out_last
);

  logic [VAL_W-1:0] mem [STORE_DEPTH];

  logic [KEY_W-1:0]     key_r,       key_nxt;
  logic [VAL_W-1:0]     smp_r,       smp_nxt;
  logic [ENTRY_W-1:0]   entry_r,     entry_nxt;
  logic [IDX_W-1:0]     wpos_r,      wpos_nxt;
  logic                 wrapped_r,   wrapped_nxt;
  logic [IDX_W-1:0]     pos_r,       pos_nxt;
  logic [SUM_W-1:0]     acc_r,       acc_nxt;
  logic [SUM_W-1:0]     quo_r,       quo_nxt;
  logic [CNT_W-1:0]     rem_r,       rem_nxt;
  logic [DCNT_W-1:0]    dcnt_r,      dcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    kind_r,      kind_nxt;
  logic [VAL_W-1:0]     value_r,     value_nxt;
  logic [OUT_IDX_W-1:0] index_r,     index_nxt;
  logic                 last_r,      last_nxt;
  logic [VAL_W-1:0]     rd_data_r;

  logic [CNT_W-1:0]   filled;
  logic [PROD_W-1:0]  entry_prod;
  logic [ENTRY_W-1:0] entry_m1;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               wrap_hit;
  logic [CNT_W-1:0]   pos_p1;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_sub;
  logic               div_ge;
  logic               can_load;

  always_comb begin
    filled     = wrapped_r ? CNT_W'(STORE_DEPTH) : CNT_W'(wpos_r);
    entry_prod = PROD_W'(entry_r) * PROD_W'(10) + PROD_W'(key_digit(key_r));
    entry_m1   = entry_r - ENTRY_W'(1);
    wrap_hit   = (wpos_r == IDX_W'(STORE_DEPTH - 1));
    pos_p1     = CNT_W'(pos_r) + CNT_W'(1);
    rd_en      = cmd.rd_show | cmd.rd_pos;
    rd_addr    = cmd.rd_show ? entry_m1[IDX_W-1:0] : pos_r;
    rem_sh     = {rem_r, quo_r[SUM_W-1]};
    div_ge     = (rem_sh >= {1'b0, filled});
    rem_sub    = div_ge ? (rem_sh - {1'b0, filled}) : rem_sh;
    can_load   = !out_valid_r || out_ready;

    sts.cls       = key_class(key_r);
    sts.show_ok   = (entry_r != '0) && (ENTRY_W'(filled) >= entry_r);
    sts.empty     = (filled == '0);
    sts.list_last = (pos_p1 == filled);
    sts.div_done  = (dcnt_r == '0);
    sts.can_load  = can_load;
  end

  always_comb begin
    key_nxt     = key_r;
    smp_nxt     = smp_r;
    entry_nxt   = entry_r;
    wpos_nxt    = wpos_r;
    wrapped_nxt = wrapped_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dcnt_nxt    = dcnt_r;

    if (cmd.capture) begin
      key_nxt = in_key_code;
      smp_nxt = in_sample & SMP_MASK;
    end
    if (cmd.digit_upd) begin
      entry_nxt = (entry_prod > PROD_W'(ENTRY_MAX)) ? ENTRY_W'(ENTRY_MAX)
                                                    : entry_prod[ENTRY_W-1:0];
    end
    if (cmd.clr_entry) entry_nxt = '0;
    if (cmd.meas_wr) begin
      wpos_nxt = wrap_hit ? '0 : wpos_r + IDX_W'(1);
      if (wrap_hit) wrapped_nxt = 1'b1;
    end
    if (cmd.rd_show) pos_nxt = entry_m1[IDX_W-1:0];
    if (cmd.pos_clr) pos_nxt = '0;
    if (cmd.pos_inc) pos_nxt = pos_r + IDX_W'(1);
    if (cmd.acc_clr) acc_nxt = '0;
    if (cmd.acc_add) acc_nxt = acc_r + SUM_W'(rd_data_r);
    if (cmd.div_start) begin
      quo_nxt  = acc_r;
      rem_nxt  = '0;
      dcnt_nxt = DCNT_W'(SUM_W);
    end
    if (cmd.div_step) begin
      quo_nxt  = {quo_r[SUM_W-2:0], div_ge};
      rem_nxt  = rem_sub[CNT_W-1:0];
      dcnt_nxt = dcnt_r - DCNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    index_nxt     = index_r;
    last_nxt      = last_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit_err) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_ERROR;
      value_nxt     = '0;
      index_nxt     = '0;
      last_nxt      = 1'b1;
    end
    if (cmd.emit_meas) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = wrap_hit ? KIND_WRAP : KIND_STORED;
      value_nxt     = smp_r;
      index_nxt     = to_out_idx(wpos_r);
      last_nxt      = 1'b1;
    end
    if (cmd.emit_show) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_SHOWN;
      value_nxt     = rd_data_r;
      index_nxt     = to_out_idx(pos_r);
      last_nxt      = 1'b1;
    end
    if (cmd.emit_list) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_LIST;
      value_nxt     = rd_data_r;
      index_nxt     = to_out_idx(pos_r);
      last_nxt      = sts.list_last;
    end
    if (cmd.emit_avg) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_AVG;
      value_nxt     = quo_r[VAL_W-1:0];
      index_nxt     = '0;
      last_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r     <= '0;
      wpos_r      <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      entry_r     <= entry_nxt;
      wpos_r      <= wpos_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    smp_r   <= smp_nxt;
    pos_r   <= pos_nxt;
    acc_r   <= acc_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    index_r <= index_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.meas_wr) mem[wpos_r] <= smp_r;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_index = index_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// ----- rtl/core/ksl_ctrl.sv -----
// Logger controller: sequences decode, store walks, division and result beats.
// Depends on ksl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ksl_ctrl
  import ksl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ksl_sts_t sts,
  output ksl_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_SHOW_OUT = 4'd2;
  localparam logic [3:0] S_LIST_RD  = 4'd3;
  localparam logic [3:0] S_LIST_OUT = 4'd4;
  localparam logic [3:0] S_SUM_RD   = 4'd5;
  localparam logic [3:0] S_SUM_ADD  = 4'd6;
  localparam logic [3:0] S_DIV_LD   = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_AVG_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.cls)
          CLS_DIGIT: begin
            cmd.digit_upd = 1'b1;
            state_nxt     = S_IDLE;
          end
          CLS_ERR: begin
            if (sts.can_load) begin
              cmd.emit_err  = 1'b1;
              cmd.clr_entry = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          CLS_MEAS: begin
            if (sts.can_load) begin
              cmd.meas_wr   = 1'b1;
              cmd.emit_meas = 1'b1;
              cmd.clr_entry = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          CLS_SHOW: begin
            if (sts.show_ok) begin
              cmd.rd_show   = 1'b1;
              cmd.clr_entry = 1'b1;
              state_nxt     = S_SHOW_OUT;
            end else if (sts.can_load) begin
              cmd.emit_err  = 1'b1;
              cmd.clr_entry = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          CLS_ALL: begin
            cmd.clr_entry = 1'b1;
            if (sts.empty) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.pos_clr = 1'b1;
              state_nxt   = S_LIST_RD;
            end
          end
          CLS_AVG: begin
            if (!sts.empty) begin
              cmd.clr_entry = 1'b1;
              cmd.pos_clr   = 1'b1;
              cmd.acc_clr   = 1'b1;
              state_nxt     = S_SUM_RD;
            end else if (sts.can_load) begin
              cmd.emit_err  = 1'b1;
              cmd.clr_entry = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SHOW_OUT: begin
        if (sts.can_load) begin
          cmd.emit_show = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LIST_RD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (sts.can_load) begin
          cmd.emit_list = 1'b1;
          if (sts.list_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pos_inc = 1'b1;
            state_nxt   = S_LIST_RD;
          end
        end
      end
      S_SUM_RD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_SUM_ADD;
      end
      S_SUM_ADD: begin
        cmd.acc_add = 1'b1;
        if (sts.list_last) begin
          state_nxt = S_DIV_LD;
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = S_SUM_RD;
        end
      end
      S_DIV_LD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_AVG_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_AVG_OUT: begin
        if (sts.can_load) begin
          cmd.emit_avg = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/keypad_sample_logger.sv -----
// Keypad sample logger. One item (scan code plus converter sample) is taken at a
// time. Error, measure and show may also wait for the output beat to drain.
// Show-all and average walk the sample store through its single read port, and
// average then runs the one-bit-per-cycle divider. The store has no reset sweep;
// an item may be taken while a finished result beat still waits.
// Depends on ksl_pkg, ksl_ctrl, ksl_dpath and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module keypad_sample_logger
  import ksl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KEY_W-1:0]     in_key_code,
  input  wire logic [VAL_W-1:0]     in_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [KIND_W-1:0]         out_kind,
  output logic [VAL_W-1:0]          out_value,
  output logic [OUT_IDX_W-1:0]      out_index,
  output logic                      out_last
);

  ksl_cmd_t cmd;
  ksl_sts_t sts;

  ksl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ksl_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_key_code (in_key_code),
    .in_sample   (in_sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .out_index   (out_index),
    .out_last    (out_last)
  );

  `ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_mid_is_list, clk, rst_n, out_valid && !out_last, out_kind == KIND_LIST)
  `ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_kind == KIND_ERROR,
              out_value == '0 && out_index == '0 && out_last)

endmodule

`default_nettype wire

// ----- sim/tb_keypad_sample_logger.sv -----
// Self-checking testbench for keypad_sample_logger: directed key table, then random
// keypad sequences; result beats checked against the table row or an in-bench logger model.
// Depends on ksl_pkg and the keypad_sample_logger RTL.
`timescale 1ns / 1ps

module tb_keypad_sample_logger;
  import ksl_pkg::*;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [VAL_W-1:0]     value;
    logic [OUT_IDX_W-1:0] index;
    logic                 last;
  } ksl_beat_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] smp;
    bit               typed;
    ksl_beat_t        res;
  } key_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [KEY_W-1:0]     in_key_code;
  logic [VAL_W-1:0]     in_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    out_kind;
  logic [VAL_W-1:0]     out_value;
  logic [OUT_IDX_W-1:0] out_index;
  logic                 out_last;

  // logger model state
  int unsigned      mdl_entry;
  logic [VAL_W-1:0] mdl_store [STORE_DEPTH];
  int unsigned      mdl_wpos;
  bit               mdl_wrapped;

  ksl_beat_t fresh_results [$];
  ksl_beat_t due_results [$];
  ksl_beat_t row_res;
  ksl_beat_t none_res;
  bit        row_typed;
  bit        calm;
  bit        stall_req;
  int        done_items;
  int        err_cnt;

  keypad_sample_logger dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_key_code (in_key_code),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .out_index   (out_index),
    .out_last    (out_last)
  );

  always #1 clk = ~clk;

  function automatic ksl_beat_t mk_beat(input logic [KIND_W-1:0] kind,
                                        input logic [VAL_W-1:0] value,
                                        input logic [OUT_IDX_W-1:0] index,
                                        input logic last);
    ksl_beat_t b;
    b.kind  = kind;
    b.value = value;
    b.index = index;
    b.last  = last;
    return b;
  endfunction

  function automatic key_row_t row(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] smp,
                                   input int typed, input logic [KIND_W-1:0] kind,
                                   input int value, input int index);
    key_row_t r;
    r.key   = key;
    r.smp   = smp;
    r.typed = (typed != 0);
    r.res   = mk_beat(kind, VAL_W'(value), OUT_IDX_W'(index), 1'b1);
    return r;
  endfunction

  function automatic int digit_value(input logic [KEY_W-1:0] key);
    case (key)
      5'd1:    return 1;
      5'd2:    return 4;
      5'd3:    return 7;
      5'd5:    return 2;
      5'd6:    return 5;
      5'd7:    return 8;
      5'd8:    return 0;
      5'd9:    return 3;
      5'd10:   return 6;
      5'd11:   return 9;
      default: return -1;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] digit_key(input int d);
    case (d)
      0:       return 5'd8;
      1:       return 5'd1;
      2:       return 5'd5;
      3:       return 5'd9;
      4:       return 5'd2;
      5:       return 5'd6;
      6:       return 5'd10;
      7:       return 5'd3;
      8:       return 5'd7;
      default: return 5'd11;
    endcase
  endfunction

  function automatic int unsigned mdl_filled();
    return mdl_wrapped ? STORE_DEPTH : mdl_wpos;
  endfunction

  // compute the result beats of one key and advance the model
  function automatic void predict_key(input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] smp_in);
    int unsigned      filled;
    int unsigned      n;
    int unsigned      sum;
    int unsigned      pos;
    int               d;
    logic [VAL_W-1:0] smp;
    smp = smp_in & SMP_MASK;
    filled = mdl_filled();
    n = mdl_entry;
    d = digit_value(key);
    fresh_results.delete();
    if (key == 0 || key > KEY_AVG) return;
    if (d >= 0) begin
      n = n * 10 + d;
      mdl_entry = (n > ENTRY_MAX) ? ENTRY_MAX : n;
      return;
    end
    mdl_entry = 0;
    case (key)
      KEY_MEASURE: begin
        pos = mdl_wpos;
        mdl_store[pos] = smp;
        if (pos + 1 >= STORE_DEPTH) begin
          mdl_wpos = 0;
          mdl_wrapped = 1'b1;
          fresh_results.push_back(mk_beat(KIND_WRAP, smp, OUT_IDX_W'(pos), 1'b1));
        end else begin
          mdl_wpos = pos + 1;
          fresh_results.push_back(mk_beat(KIND_STORED, smp, OUT_IDX_W'(pos), 1'b1));
        end
      end
      KEY_SHOW: begin
        if (n == 0 || n > filled)
          fresh_results.push_back(mk_beat(KIND_ERROR, '0, '0, 1'b1));
        else
          fresh_results.push_back(mk_beat(KIND_SHOWN, mdl_store[n-1], OUT_IDX_W'(n - 1), 1'b1));
      end
      KEY_ALL: begin
        for (int j = 0; j < filled; j++)
          fresh_results.push_back(mk_beat(KIND_LIST, mdl_store[j], OUT_IDX_W'(j),
                                          (j + 1 == filled)));
      end
      KEY_AVG: begin
        if (filled == 0) begin
          fresh_results.push_back(mk_beat(KIND_ERROR, '0, '0, 1'b1));
        end else begin
          sum = 0;
          for (int j = 0; j < filled; j++) sum += mdl_store[j];
          fresh_results.push_back(mk_beat(KIND_AVG, VAL_W'(sum / filled), '0, 1'b1));
        end
      end
      default: fresh_results.push_back(mk_beat(KIND_ERROR, '0, '0, 1'b1));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: out_%s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin : beat_check
    ksl_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_key(in_key_code, in_sample);
        if (row_typed) due_results.push_back(row_res);
        else foreach (fresh_results[i]) due_results.push_back(fresh_results[i]);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat expected none, got kind %0d value %0d index %0d last %0d",
                   $time, out_kind, out_value, out_index, out_last);
        end else begin
          want = due_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("value", 16'(want.value), 16'(out_value));
          check_field("index", 16'(want.index), 16'(out_index));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
    end
  end

  initial begin : receiver
    int  run_left;
    bit  level;
    run_left = 0;
    level = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        run_left = 400;
        level = 1'b0;
      end else if (run_left == 0) begin
        level = !level;
        run_left = level ? $urandom_range(1, 12) : pick_gap();
        if (run_left == 0) begin
          level = 1'b1;
          run_left = $urandom_range(1, 12);
        end
      end
      out_ready <= level;
      run_left--;
    end
  end

  initial begin : watchdog
    #8000000;
    $display("tb_keypad_sample_logger: done, errors");
    $finish;
  end

  task automatic send_beat(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] smp,
                           input bit typed, input ksl_beat_t res);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_key_code <= key;
    in_sample   <= smp;
    row_typed = typed;
    row_res = res;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (key >= 1 && key <= KEY_AVG) done_items++;
    @(negedge clk);
  endtask

  task automatic send_key(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] smp);
    send_beat(key, smp, 1'b0, none_res);
  endtask

  task automatic send_number(input int n);
    int digs [$];
    int v;
    v = n;
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 7) == 0) digs.push_front(0);
    foreach (digs[i]) send_key(digit_key(digs[i]), VAL_W'($urandom));
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  initial begin : stimulus
    key_row_t         rows [$];
    int               r;
    int               n;
    bit               stall_done;
    bit               pause_done;
    logic [VAL_W-1:0] s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key_code = '0;
    in_sample = '0;
    row_typed = 1'b0;
    none_res = mk_beat('0, '0, '0, 1'b0);
    row_res = none_res;
    calm = 1'b0;
    stall_req = 1'b0;
    stall_done = 1'b0;
    pause_done = 1'b0;
    done_items = 0;
    err_cnt = 0;
    mdl_entry = 0;
    mdl_wpos = 0;
    mdl_wrapped = 1'b0;

    //                 key          sample           typed kind         value  index
    rows.push_back(row(KEY_AVG,     VAL_W'($urandom), 1, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_ALL,     VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_SHOW,    VAL_W'($urandom), 1, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_ERR_A,   VAL_W'($urandom), 1, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_ERR_B,   VAL_W'($urandom), 1, KIND_ERROR,  0,    0));
    rows.push_back(row(5'd0,        VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(5'd31,       VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(5'd17,       VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_MEASURE, 10'd1023,         1, KIND_STORED, 1023, 0));
    rows.push_back(row(KEY_MEASURE, 10'd0,            1, KIND_STORED, 0,    1));
    rows.push_back(row(5'd1,        VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_SHOW,    VAL_W'($urandom), 1, KIND_SHOWN,  1023, 0));
    repeat (5) rows.push_back(row(5'd11, VAL_W'($urandom), 0, KIND_ERROR, 0, 0));
    rows.push_back(row(KEY_SHOW,    VAL_W'($urandom), 1, KIND_ERROR,  0,    0));
    rows.push_back(row(5'd5,        VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_SHOW,    VAL_W'($urandom), 1, KIND_SHOWN,  0,    1));
    rows.push_back(row(KEY_ALL,     VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_AVG,     VAL_W'($urandom), 1, KIND_AVG,    511,  0));
    rows.push_back(row(5'd1,        VAL_W'($urandom), 0, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_ERR_A,   VAL_W'($urandom), 1, KIND_ERROR,  0,    0));
    rows.push_back(row(KEY_SHOW,    VAL_W'($urandom), 1, KIND_ERROR,  0,    0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_beat(rows[i].key, rows[i].smp, rows[i].typed, rows[i].res);

    while (done_items < 400) begin
      calm = (done_items >= 150 && done_items < 200);
      if (!stall_done && done_items >= 250) begin
        // hold the receiver off and keep offering beats until the input stalls
        stall_done = 1'b1;
        stall_req = 1'b1;
        repeat (12) send_key(KEY_MEASURE, VAL_W'($urandom));
      end
      if (!pause_done && done_items >= 300) begin
        pause_done = 1'b1;
        wait_drained(100);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        s = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : VAL_W'($urandom);
        send_key(KEY_MEASURE, s);
      end else if (r < 60) begin
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, mdl_filled() + 1)
                                       : $urandom_range(0, 60);
        send_number(n);
        if ($urandom_range(0, 9) == 0) send_key(KEY_AVG, VAL_W'($urandom));
        else send_key(KEY_SHOW, VAL_W'($urandom));
      end else if (r < 68) begin
        send_key(KEY_ALL, VAL_W'($urandom));
      end else if (r < 76) begin
        send_key(KEY_AVG, VAL_W'($urandom));
      end else if (r < 82) begin
        send_key($urandom_range(0, 1) ? KEY_ERR_A : KEY_ERR_B, VAL_W'($urandom));
      end else if (r < 90) begin
        send_key(KEY_W'($urandom_range(0, 31)), VAL_W'($urandom));
      end else begin
        repeat ($urandom_range(4, 6)) send_key(digit_key($urandom_range(0, 9)), VAL_W'($urandom));
        send_key(KEY_SHOW, VAL_W'($urandom));
      end
    end

    wait_drained(200);
    if (err_cnt == 0)
      $display("tb_keypad_sample_logger: done, clean");
    else
      $display("tb_keypad_sample_logger: done, errors");
    $finish;
  end

endmodule
